// File: hw/rtl/spoe_pkg.sv
// Shared types and constants for the slot pool with oldest-slot eviction.
// Holds the request and response beat layouts and the link memory command.
// Depends on nothing; every other file in the block imports it.
`default_nettype none

package spoe_pkg;

   localparam int SLOT_FIELD_W  = 10;
   localparam int COUNT_FIELD_W = 11;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [COUNT_FIELD_W-1:0] MAX_ACTIVE_RESET = 11'd1024;

   // Register index as decoded from paddr[2].
   localparam logic REG_MAX_ACTIVE = 1'b0;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef struct packed {
      op_type                  op;
      logic [SLOT_FIELD_W-1:0] slot_in;
   } req_type;

   typedef struct packed {
      logic [SLOT_FIELD_W-1:0]  slot_out;
      logic                     evicted;
      logic [SLOT_FIELD_W-1:0]  evicted_slot;
      logic                     fault;
      logic [COUNT_FIELD_W-1:0] active_count;
   } rsp_type;

   // Controls for the two link memories: one read of both at the same slot,
   // one write to the successor memory and field writes to the side memory.
   typedef struct packed {
      logic rd_en;
      logic next_we;
      logic act_we;
      logic prev_we;
      logic act_val;
   } mem_cmd_type;

endpackage

`default_nettype wire

// File: hw/rtl/spoe_link_mem.sv
// Link storage for the slot pool: successor memory and side memory (active
// flag plus predecessor), both with a registered read.
// Depends on spoe_pkg for the memory command type.
`default_nettype none

module spoe_link_mem import spoe_pkg::*; #(
   parameter  int POOL_SLOTS = 1024,
   localparam int SLOT_W     = $clog2(POOL_SLOTS)
) (
   input  wire logic              clock,
   input  wire mem_cmd_type       mem_cmd,
   input  wire logic [SLOT_W-1:0] rd_addr,
   input  wire logic [SLOT_W-1:0] next_addr,
   input  wire logic [SLOT_W-1:0] next_data,
   input  wire logic [SLOT_W-1:0] side_addr,
   input  wire logic [SLOT_W-1:0] prev_data,
   output logic      [SLOT_W-1:0] next_q,
   output logic      [SLOT_W-1:0] prev_q,
   output logic                   act_q
);

   typedef struct packed {
      logic              act;
      logic [SLOT_W-1:0] prev;
   } side_row_type;

   logic [SLOT_W-1:0] next_link_ff [POOL_SLOTS];
   side_row_type      side_link_ff [POOL_SLOTS];

   logic [SLOT_W-1:0] next_q_ff;
   side_row_type      side_q_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.next_we) begin
         next_link_ff[next_addr] <= next_data;
      end
      if (mem_cmd.rd_en) begin
         next_q_ff <= next_link_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.act_we) begin
         side_link_ff[side_addr].act <= mem_cmd.act_val;
      end
      if (mem_cmd.prev_we) begin
         side_link_ff[side_addr].prev <= prev_data;
      end
      if (mem_cmd.rd_en) begin
         side_q_ff <= side_link_ff[rd_addr];
      end
   end

   assign next_q = next_q_ff;
   assign prev_q = side_q_ff.prev;
   assign act_q  = side_q_ff.act;

endmodule

`default_nettype wire

// File: hw/rtl/spoe_ctrl.sv
// Sequencer for the slot pool: list heads, counters, fill mark and the
// read-modify-write steps on the link memories, plus the response register.
// Depends on spoe_pkg for beat layouts, operation codes and memory commands.
`default_nettype none

module spoe_ctrl import spoe_pkg::*; #(
   parameter  int POOL_SLOTS = 1024,
   localparam int SLOT_W     = $clog2(POOL_SLOTS),
   localparam int CNT_W      = $clog2(POOL_SLOTS + 1)
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp_data,
   input  wire logic [COUNT_FIELD_W-1:0] max_active,
   output mem_cmd_type                   mem_cmd,
   output logic      [SLOT_W-1:0]        rd_addr,
   output logic      [SLOT_W-1:0]        next_addr,
   output logic      [SLOT_W-1:0]        next_data,
   output logic      [SLOT_W-1:0]        side_addr,
   output logic      [SLOT_W-1:0]        prev_data,
   input  wire logic [SLOT_W-1:0]        next_q,
   input  wire logic [SLOT_W-1:0]        prev_q,
   input  wire logic                     act_q
);

   localparam int CMP_W = (CNT_W + 1 > COUNT_FIELD_W) ? CNT_W + 1 : COUNT_FIELD_W;
   localparam logic [CNT_W-1:0] POOL_COUNT = CNT_W'(POOL_SLOTS);
   localparam logic [CNT_W-1:0] COUNT_ONE  = CNT_W'(1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TAIL
   } state_type;

   state_type         state_ff, state_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   op_type            op_ff, op_in;
   logic [SLOT_W-1:0] sin_ff, sin_in;
   logic              sin_ok_ff, sin_ok_in;
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic              free_empty_ff, free_empty_in;
   logic [SLOT_W-1:0] newest_ff, newest_in;
   logic [SLOT_W-1:0] oldest_ff, oldest_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  mark_ff, mark_in;

   logic              out_free;
   logic              accept;
   logic [SLOT_W-1:0] req_idx;
   logic              req_ok;
   logic [CNT_W-1:0]  total_dec;
   logic              use_free;
   logic [SLOT_W-1:0] alloc_slot;
   logic              alloc_pristine;
   logic [SLOT_W-1:0] alloc_succ;
   logic [CNT_W-1:0]  alloc_total;
   logic              alloc_linked;
   logic              free_active;
   logic              is_old;
   logic              is_new;
   logic              middle;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign req_idx   = SLOT_W'(req_data.slot_in);
   assign req_ok    = 32'(req_data.slot_in) < 32'(POOL_SLOTS);
   assign total_dec = (total_ff != '0) ? total_ff - COUNT_ONE : '0;

   assign use_free = !free_empty_ff &&
                     ((total_ff == '0) ||
                      (CMP_W'(total_ff) + CMP_W'(1) < CMP_W'(max_active)));
   assign alloc_slot = use_free ? free_head_ff : oldest_ff;

   // Slots at or above the fill mark have never been touched since the last
   // clear, so their successor is simply the next index, wrapping to zero.
   assign alloc_pristine = CNT_W'(alloc_slot) >= mark_ff;
   assign alloc_succ     = (CNT_W'(alloc_slot) + COUNT_ONE == POOL_COUNT) ? '0 :
                           SLOT_W'(CNT_W'(alloc_slot) + COUNT_ONE);
   assign alloc_total    = use_free ? total_ff + COUNT_ONE : total_dec + COUNT_ONE;
   assign alloc_linked   = use_free ? (total_ff != '0) : (total_dec != '0);

   assign free_active = sin_ok_ff && (CNT_W'(sin_ff) < mark_ff) && act_q;
   assign is_old      = (sin_ff == oldest_ff);
   assign is_new      = (sin_ff == newest_ff);
   assign middle      = free_active && !is_old && !is_new;

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      op_in         = op_ff;
      sin_in        = sin_ff;
      sin_ok_in     = sin_ok_ff;
      free_head_in  = free_head_ff;
      free_empty_in = free_empty_ff;
      newest_in     = newest_ff;
      oldest_in     = oldest_ff;
      total_in      = total_ff;
      mark_in       = mark_ff;
      mem_cmd       = '0;
      rd_addr       = alloc_slot;
      next_addr     = newest_ff;
      next_data     = alloc_slot;
      side_addr     = alloc_slot;
      prev_data     = newest_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mem_cmd.rd_en = 1'b1;
               rd_addr       = (req_data.op == OP_FREE) ? req_idx : alloc_slot;
               op_in         = req_data.op;
               sin_in        = req_idx;
               sin_ok_in     = req_ok;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               OP_ALLOC: begin
                  if (out_free) begin
                     mem_cmd.next_we = alloc_linked;
                     mem_cmd.act_we  = 1'b1;
                     mem_cmd.act_val = 1'b1;
                     mem_cmd.prev_we = alloc_linked;
                     if (use_free) begin
                        free_head_in = alloc_pristine ? alloc_succ : next_q;
                        if (alloc_pristine) begin
                           mark_in = mark_ff + COUNT_ONE;
                        end
                     end
                     if (!alloc_linked) begin
                        oldest_in = alloc_slot;
                     end else if (!use_free) begin
                        oldest_in = next_q;
                     end
                     newest_in     = alloc_slot;
                     total_in      = alloc_total;
                     free_empty_in = alloc_total >= POOL_COUNT;
                     rsp_data_in.slot_out     = SLOT_FIELD_W'(alloc_slot);
                     rsp_data_in.evicted      = !use_free;
                     rsp_data_in.evicted_slot = use_free ? '0 : SLOT_FIELD_W'(alloc_slot);
                     rsp_data_in.fault        = 1'b0;
                     rsp_data_in.active_count = COUNT_FIELD_W'(alloc_total);
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               OP_FREE: begin
                  if (middle) begin
                     // Bridge the neighbours first; the slot itself goes on
                     // the free chain in the next step.
                     mem_cmd.next_we = 1'b1;
                     mem_cmd.prev_we = 1'b1;
                     next_addr       = prev_q;
                     next_data       = next_q;
                     side_addr       = next_q;
                     prev_data       = prev_q;
                     state_in        = ST_TAIL;
                  end else if (out_free) begin
                     if (free_active) begin
                        mem_cmd.next_we = 1'b1;
                        mem_cmd.act_we  = 1'b1;
                        next_addr       = sin_ff;
                        next_data       = free_head_ff;
                        side_addr       = sin_ff;
                        if (is_old && !is_new) begin
                           oldest_in = next_q;
                        end
                        if (is_new && !is_old) begin
                           newest_in = prev_q;
                        end
                        free_head_in  = sin_ff;
                        free_empty_in = 1'b0;
                        total_in      = total_dec;
                     end
                     rsp_data_in              = '0;
                     rsp_data_in.fault        = !free_active;
                     rsp_data_in.active_count = COUNT_FIELD_W'(free_active ? total_dec : total_ff);
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
               OP_CLEAR: begin
                  if (out_free) begin
                     mark_in       = '0;
                     free_head_in  = '0;
                     free_empty_in = 1'b0;
                     total_in      = '0;
                     rsp_data_in   = '0;
                     rsp_valid_in  = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               default: begin
                  if (out_free) begin
                     rsp_data_in              = '0;
                     rsp_data_in.active_count = COUNT_FIELD_W'(total_ff);
                     rsp_valid_in = 1'b1;
                     state_in     = ST_IDLE;
                  end
               end
            endcase
         end
         ST_TAIL: begin
            if (out_free) begin
               mem_cmd.next_we = 1'b1;
               mem_cmd.act_we  = 1'b1;
               next_addr       = sin_ff;
               next_data       = free_head_ff;
               side_addr       = sin_ff;
               free_head_in    = sin_ff;
               free_empty_in   = 1'b0;
               total_in        = total_dec;
               rsp_data_in              = '0;
               rsp_data_in.active_count = COUNT_FIELD_W'(total_dec);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         free_head_ff  <= '0;
         free_empty_ff <= 1'b0;
         newest_ff     <= '0;
         oldest_ff     <= '0;
         total_ff      <= '0;
         mark_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         free_head_ff  <= free_head_in;
         free_empty_ff <= free_empty_in;
         newest_ff     <= newest_in;
         oldest_ff     <= oldest_in;
         total_ff      <= total_in;
         mark_ff       <= mark_in;
      end
      rsp_data_ff <= rsp_data_in;
      op_ff       <= op_in;
      sin_ff      <= sin_in;
      sin_ok_ff   <= sin_ok_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// File: hw/rtl/slot_pool_oldest_eviction_core.sv
// Slot pool with a free chain and an age-ordered active list; when the pool
// is full or the active limit is reached, alloc reuses the oldest slot.
// Depends on spoe_pkg, spoe_ctrl and spoe_link_mem.
//
// Usage: a request beat on req_ (valid/ready) carries an operation (alloc,
// free a given slot, clear) and a slot index; every request produces exactly
// one response beat on rsp_, in request order, with the granted slot, the
// eviction flag and slot, the fault flag and the active count afterwards.
// The APB port holds one register, max_active, at byte address 0.
//
// Timing: the accepting cycle issues the read of both link memories; the execute
// state then writes them back and loads the response register, which drives the
// response, waiting while that register still holds an untaken beat. A free from
// the middle of the age list also passes a tail state, as it needs two writes to
// each link memory, which has one write port. No further request is taken until
// the current one has finished, which keeps memory accesses from overlapping.
//
// Clear is an ordinary item, as a fill mark treats every slot at or above it as
// untouched and no clearing pass is run. If the receiver stalls, a finished
// beat waits in the response register while the next request is still
// accepted; that request then holds before its final write.
`default_nettype none

module slot_pool_oldest_eviction_core import spoe_pkg::*; #(
   parameter int POOL_SLOTS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int SLOT_W = $clog2(POOL_SLOTS);

   // The limit register. Writes are only expected while the pool is idle, so
   // the sequencer may read it at any time without a shadow copy.
   logic [COUNT_FIELD_W-1:0] max_active_ff, max_active_in;
   logic                     csr_write;

   mem_cmd_type       mem_cmd;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] next_addr;
   logic [SLOT_W-1:0] next_data;
   logic [SLOT_W-1:0] side_addr;
   logic [SLOT_W-1:0] prev_data;
   logic [SLOT_W-1:0] next_q;
   logic [SLOT_W-1:0] prev_q;
   logic              act_q;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Only the first word holds a register; writes above it are dropped and
   // reads return zero.
   always_comb begin
      max_active_in = max_active_ff;
      if (csr_write && (paddr[2] == REG_MAX_ACTIVE)) begin
         max_active_in = pwdata[COUNT_FIELD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_active_ff <= MAX_ACTIVE_RESET;
      end else begin
         max_active_ff <= max_active_in;
      end
   end

   assign prdata = (paddr[2] == REG_MAX_ACTIVE) ? CSR_DATA_W'(max_active_ff) : '0;

   // The sequencer owns the list heads, counters and the response register;
   // the link memory holds successor, predecessor and active flag per slot.
   spoe_ctrl #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .max_active (max_active_ff),
      .mem_cmd    (mem_cmd),
      .rd_addr    (rd_addr),
      .next_addr  (next_addr),
      .next_data  (next_data),
      .side_addr  (side_addr),
      .prev_data  (prev_data),
      .next_q     (next_q),
      .prev_q     (prev_q),
      .act_q      (act_q)
   );

   spoe_link_mem #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_mem (
      .clock     (clock),
      .mem_cmd   (mem_cmd),
      .rd_addr   (rd_addr),
      .next_addr (next_addr),
      .next_data (next_data),
      .side_addr (side_addr),
      .prev_data (prev_data),
      .next_q    (next_q),
      .prev_q    (prev_q),
      .act_q     (act_q)
   );

endmodule

`default_nettype wire

// File: hw/rtl/spoe_checker.sv
// Port-level checks for the slot pool, attached to the top level by bind.
// Depends on spoe_pkg for the response beat layout.
`default_nettype none

module spoe_checker import spoe_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_ready,
   input wire logic    rsp_valid,
   input wire logic    rsp_ready,
   input wire rsp_type rsp_data
);

   // A response beat that is not taken stays put.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // Only one request is in flight: ready drops after every accepted beat.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request accepted while one is in progress");

   // An eviction reports the reused slot in both slot fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.evicted |-> rsp_data.evicted_slot == rsp_data.slot_out)
      else $error("evicted slot differs from granted slot");

   // A rejected free grants nothing and evicts nothing.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault |->
         !rsp_data.evicted && (rsp_data.slot_out == '0) && (rsp_data.evicted_slot == '0))
      else $error("faulting beat carries a grant or eviction");

endmodule

bind slot_pool_oldest_eviction_core spoe_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// File: tb/slot_pool_oldest_eviction_core_tb.sv
// Self-checking bench for the slot pool with oldest-slot eviction.
// Drives request beats and the APB limit register, and predicts every response beat.
// Depends on spoe_pkg and slot_pool_oldest_eviction_core.
`default_nettype none

module slot_pool_oldest_eviction_core_tb import spoe_pkg::*; ();

   localparam int SLOTS       = 1024;
   // Cycles without a single accepted beat or register write before giving up.
   localparam int STALL_LIMIT = 3000;

   typedef logic [SLOT_FIELD_W-1:0]  slot_type;
   typedef logic [COUNT_FIELD_W-1:0] count_type;

   // Mirror of the pool: a free chain and an age-ordered active list. Each
   // accepted request is applied here in order, and the response beat it must
   // produce is queued until the block hands one back.
   class slot_pool_tracker;
      slot_type  succ[SLOTS];
      slot_type  pred[SLOTS];
      bit        live[SLOTS];
      slot_type  free_head;
      bit        free_none;
      slot_type  newest;
      slot_type  oldest;
      count_type total;
      count_type limit;
      rsp_type   awaited_rsp[$];
      int        errors;

      function new();
         limit  = MAX_ACTIVE_RESET;
         newest = '0;
         oldest = '0;
         errors = 0;
         rebuild();
      endfunction

      function void rebuild();
         for (int i = 0; i < SLOTS; i++) begin
            succ[i] = slot_type'((i + 1) % SLOTS);
            live[i] = 1'b0;
         end
         free_head = '0;
         free_none = 1'b0;
         total     = '0;
      endfunction

      function void set_limit(count_type value);
         limit = value;
      endfunction

      function int pending();
         return awaited_rsp.size();
      endfunction

      // Takes an active slot out of the age list, patching its neighbours.
      function void unlink(slot_type s);
         slot_type nx;
         slot_type pv;
         nx = succ[s];
         pv = pred[s];
         if (s == oldest && s == newest) begin
            // The list is now empty; the end pointers are left as they are.
         end else if (s == oldest) begin
            oldest = nx;
         end else if (s == newest) begin
            newest = pv;
         end else begin
            succ[pv] = nx;
            pred[nx] = pv;
         end
         live[s] = 1'b0;
         if (total != 0) total--;
      endfunction

      function void append(slot_type s);
         if (total == 0) begin
            oldest = s;
         end else begin
            succ[newest] = s;
            pred[s]      = newest;
         end
         newest  = s;
         live[s] = 1'b1;
         total++;
      endfunction

      function void note_request(req_type item);
         rsp_type  want;
         slot_type s;
         want = '0;
         case (item.op)
            OP_ALLOC: begin
               // An empty active list always takes a free slot, whatever the limit.
               if (!free_none && (total == 0 || int'(total) + 1 < int'(limit))) begin
                  s         = free_head;
                  free_head = succ[s];
               end else begin
                  s = oldest;
                  unlink(s);
                  want.evicted      = 1'b1;
                  want.evicted_slot = s;
               end
               append(s);
               free_none     = (total >= SLOTS);
               want.slot_out = s;
            end
            OP_FREE: begin
               if (!live[item.slot_in]) begin
                  want.fault = 1'b1;
               end else begin
                  unlink(item.slot_in);
                  succ[item.slot_in] = free_head;
                  free_head          = item.slot_in;
                  free_none          = 1'b0;
               end
            end
            OP_CLEAR: begin
               rebuild();
            end
            default: begin
            end
         endcase
         want.active_count = total;
         awaited_rsp.push_back(want);
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         if (awaited_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("response beat with nothing outstanding: slot %0d count %0d",
                        got.slot_out, got.active_count);
            return;
         end
         want = awaited_rsp.pop_front();
         if (got.slot_out !== want.slot_out || got.evicted !== want.evicted ||
             got.evicted_slot !== want.evicted_slot || got.fault !== want.fault ||
             got.active_count !== want.active_count) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: expected slot %0d evicted %0b/%0d fault %0b count %0d,",
                        want.slot_out, want.evicted, want.evicted_slot, want.fault,
                        want.active_count);
               $display("          got slot %0d evicted %0b/%0d fault %0b count %0d",
                        got.slot_out, got.evicted, got.evicted_slot, got.fault,
                        got.active_count);
            end
         end
      endfunction

      // Finds an active slot, searching upwards from a given start.
      function slot_type pick_live(slot_type start);
         for (int i = 0; i < SLOTS; i++)
            if (live[slot_type'(start + i)]) return slot_type'(start + i);
         return start;
      endfunction
   endclass

   // Every input of the block starts at a known value.
   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr     = '0;
   logic [CSR_DATA_W-1:0] pwdata    = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   slot_pool_tracker tracker;
   // When set, neither side idles, so beats run back to back for a whole phase.
   bit calm = 1'b0;
   int hold_left = 0;
   int quiet = 0;

   slot_pool_oldest_eviction_core #(
      .POOL_SLOTS(SLOTS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #6 clock = ~clock;

   // Idle length: usually none; otherwise a random gap, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   function automatic req_type make_req(op_type op, slot_type s);
      req_type t;
      t.op      = op;
      t.slot_in = s;
      return t;
   endfunction

   // The receiving side stalls at random; a stall always ends with ready
   // raised before the next one may start.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm) hold_left = pick_gap();
      end
   end

   // Response beats are sampled at the edge with the values from before it,
   // so nothing here depends on the order of processes within the step.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) tracker.check_response(rsp_data);
   end

   // Watchdog: any accepted beat or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable && pready)) begin
         quiet = 0;
      end else begin
         quiet++;
         if (quiet == STALL_LIMIT) begin
            $display("FAIL slot_pool_oldest_eviction_core");
            $finish;
         end
      end
   end

   // Offers one request beat and holds it until accepted. The prediction is
   // made at the accepting edge, so the next item can be chosen from the
   // pool as the block now sees it. Valid only drops when a gap follows.
   task automatic send_req(req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(item);
      gap = calm ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits for every outstanding response and then lets the block settle before it is treated as idle.
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write of the limit register: a setup phase, then the access phase.
   task automatic csr_write(count_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {REG_MAX_ACTIVE, 2'b00};
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      tracker.set_limit(value);
   endtask

   // One phase of random traffic under a given limit. Frees mostly name a
   // slot that is really active (oldest, newest or one found by search), so
   // the age list gets exercised; the rest name any slot, active or not.
   task automatic run_phase(count_type limit, int beats, int alloc_pct, int clear_pct);
      int       r;
      int       q;
      slot_type s;
      settle();
      csr_write(limit);
      calm = ($urandom_range(3) == 0);
      for (int n = 0; n < beats; n++) begin
         r = $urandom_range(99);
         if (r < alloc_pct) begin
            send_req(make_req(OP_ALLOC, slot_type'($urandom)));
         end else if (r < alloc_pct + clear_pct) begin
            send_req(make_req(OP_CLEAR, slot_type'($urandom)));
         end else if (r < alloc_pct + clear_pct + 2) begin
            send_req(make_req(OP_NOP, slot_type'($urandom)));
         end else begin
            q = $urandom_range(9);
            if (q < 8 && tracker.total != 0) begin
               if (q == 0) s = tracker.oldest;
               else if (q == 1) s = tracker.newest;
               else s = tracker.pick_live(slot_type'($urandom));
            end else begin
               s = slot_type'($urandom);
            end
            send_req(make_req(OP_FREE, s));
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening under the reset limit: four grants in index order,
      // then frees from the middle, the oldest end and the newest end of the
      // age list, a repeated free and a free of the top slot (both faults),
      // a no-op, two more grants, and a clear followed by a fresh grant.
      send_req(make_req(OP_ALLOC, '1));
      for (int i = 0; i < 3; i++) send_req(make_req(OP_ALLOC, '0));
      send_req(make_req(OP_FREE, slot_type'(2)));
      send_req(make_req(OP_FREE, slot_type'(0)));
      send_req(make_req(OP_FREE, slot_type'(3)));
      send_req(make_req(OP_FREE, slot_type'(0)));
      send_req(make_req(OP_FREE, '1));
      send_req(make_req(OP_NOP, '1));
      send_req(make_req(OP_ALLOC, '0));
      send_req(make_req(OP_ALLOC, '0));
      send_req(make_req(OP_CLEAR, '1));
      send_req(make_req(OP_ALLOC, '0));

      // A limit of one evicts on every grant while anything is active, but an
      // empty active list must still take from the free chain.
      settle();
      csr_write(count_type'(1));
      send_req(make_req(OP_ALLOC, '0));
      send_req(make_req(OP_ALLOC, '0));
      send_req(make_req(OP_FREE, tracker.newest));
      send_req(make_req(OP_ALLOC, '0));
      settle();
      csr_write(count_type'(0));
      send_req(make_req(OP_ALLOC, '0));
      send_req(make_req(OP_ALLOC, '0));

      // The long phase with the widest limit fills all 1024 slots, so the
      // free chain runs dry and grants fall back to eviction. The phase after
      // it meets a full pool with the reset limit in place.
      run_phase(count_type'(2047), 1250, 95, 0);
      run_phase(count_type'(1024), 150, 60, 2);
      run_phase(count_type'(1), 70, 50, 3);
      run_phase(count_type'(0), 60, 50, 3);
      run_phase(count_type'(2), 80, 55, 3);
      run_phase(count_type'(3), 80, 55, 3);
      run_phase(count_type'(7), 80, 60, 3);
      run_phase(count_type'(16), 120, 60, 2);

      settle();
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("PASS slot_pool_oldest_eviction_core");
      end else begin
         $display("FAIL slot_pool_oldest_eviction_core");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
hw/rtl/spoe_pkg.sv
hw/rtl/spoe_link_mem.sv
hw/rtl/spoe_ctrl.sv
hw/rtl/slot_pool_oldest_eviction_core.sv
hw/rtl/spoe_checker.sv
tb/slot_pool_oldest_eviction_core_tb.sv
